[src/iee_pkg.sv]
// Shared types, sizes and codes of the infix expression evaluator.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package iee_pkg;

  localparam int OP_DEPTH  = 32;
  localparam int VAL_DEPTH = 32;
  localparam int VAL_W     = 32;
  localparam int OCNT_W    = $clog2(OP_DEPTH + 1);
  localparam int VCNT_W    = $clog2(VAL_DEPTH + 1);
  localparam int DCNT_W    = $clog2(VAL_W);

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [7:0]       op_entry_t;

  // lexeme kinds
  localparam logic [2:0] MODE_NUM   = 3'd0;
  localparam logic [2:0] MODE_OPER  = 3'd1;
  localparam logic [2:0] MODE_OPEN  = 3'd2;
  localparam logic [2:0] MODE_CLOSE = 3'd3;
  localparam logic [2:0] MODE_END   = 3'd4;

  // operator codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  localparam op_entry_t BRACKET_ENTRY = 8'h80;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEX_ERR   = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_MISSING   = 3'd4,
    ST_EXTRA     = 3'd5,
    ST_DIV_ZERO  = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_t;

  // per-cell move: keep, take from the neighbor nearer the top, take from below
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_UP   = 2'd1,
    CELL_DOWN = 2'd2
  } cell_cmd_t;

  typedef enum logic [1:0] {
    VC_HOLD = 2'd0,
    VC_PUSH = 2'd1,
    VC_REPL = 2'd2,
    VC_BIN  = 2'd3
  } vchain_cmd_t;

  typedef enum logic [1:0] {
    OC_HOLD = 2'd0,
    OC_PUSH = 2'd1,
    OC_POP  = 2'd2
  } ochain_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_OP,
    S_POP_CLOSE,
    S_POP_END,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[src/iee_val_cell.sv]
// One entry of the value stack chain.
// Depends on iee_pkg.
`default_nettype none
module iee_val_cell (
  input  wire                 clk,
  input  iee_pkg::cell_cmd_t  cmd,
  input  iee_pkg::val_t       up_val,
  input  iee_pkg::val_t       down_val,
  output iee_pkg::val_t       q
);
  import iee_pkg::*;

  val_t val_r;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_UP:   val_r <= up_val;
      CELL_DOWN: val_r <= down_val;
      default:   val_r <= val_r;
    endcase
  end

  assign q = val_r;

endmodule
`default_nettype wire

[src/iee_op_cell.sv]
// One entry of the operator stack chain.
// Depends on iee_pkg.
`default_nettype none
module iee_op_cell (
  input  wire                 clk,
  input  iee_pkg::cell_cmd_t  cmd,
  input  iee_pkg::op_entry_t  up_val,
  input  iee_pkg::op_entry_t  down_val,
  output iee_pkg::op_entry_t  q
);
  import iee_pkg::*;

  op_entry_t ent_r;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_UP:   ent_r <= up_val;
      CELL_DOWN: ent_r <= down_val;
      default:   ent_r <= ent_r;
    endcase
  end

  assign q = ent_r;

endmodule
`default_nettype wire

[src/iee_divider.sv]
// Signed restoring divider, one quotient bit per cycle, truncating.
// Depends on iee_pkg.
`default_nettype none
module iee_divider (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  input  iee_pkg::val_t  num,
  input  iee_pkg::val_t  den,
  output logic           done,
  output iee_pkg::val_t  quot
);
  import iee_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DCNT_W-1:0] cnt_r;
  val_t              rem_r;
  val_t              quo_r;
  val_t              den_r;
  logic              neg_r;
  logic [VAL_W:0]    trial;

  assign trial = {rem_r, quo_r[VAL_W-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(VAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num[VAL_W-1] ? (-num) : num;
      den_r <= den[VAL_W-1] ? (-den) : den;
      neg_r <= num[VAL_W-1] ^ den[VAL_W-1];
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[VAL_W]) begin
        rem_r <= trial[VAL_W-1:0];
        quo_r <= {quo_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[VAL_W-2:0], quo_r[VAL_W-1]};
        quo_r <= {quo_r[VAL_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = neg_r ? (-quo_r) : quo_r;

endmodule
`default_nettype wire

[src/infix_expression_evaluator_core.sv]
// Top level of the shunting-yard expression evaluator.
// Depends on iee_pkg, iee_val_cell, iee_op_cell and iee_divider.
// Input channel (in_valid/in_stall): one lexeme per item. in_stall is low
//   only while the block is idle, so items are taken one at a time.
// Output channel (out_valid/out_stall): one item per end lexeme with the
//   expression value and a status code. Other lexemes give no item.
// Handling per item:
//   number, open bracket, bad lexeme: handled in idle, the next item may follow.
//   operator, close, end: the block leaves idle, pops stack entries one by
//   one, then looks at the stack top once more (not needed when a close
//   pops its bracket); an applied operator passes the execute state (add,
//   sub, negate, missing operand, divide by zero), multiply also a state
//   with the product registered, divide waiting one quotient bit per cycle.
// End: the result sits in the output register until out_stall is low; the
//   block then clears both stacks and its errors.
// Stacks: shift chains of cells, top of stack in cell 0; a push moves every
//   cell down one place, a pop moves every cell up. Counters track fill;
//   cell contents need no reset.
// Reset: rst_n (synchronous, low) empties both stacks, clears the errors
//   and drops any pending result.
`default_nettype none
module infix_expression_evaluator_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_mode,
  input  wire  [2:0]  in_operator_code,
  input  wire  [2:0]  in_priority_req,
  input  wire  signed [31:0] in_number_value,
  output logic        out_valid,
  input  wire         out_stall,
  output logic signed [31:0] out_result_value,
  output logic [2:0]  out_status
);
  import iee_pkg::*;

  state_t             state_r, state_nxt;
  state_t             ret_r, ret_nxt;
  logic [OCNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  status_t            perr_r, perr_nxt;
  status_t            eerr_r, eerr_nxt;
  logic [2:0]         prio_r, prio_nxt;
  logic [2:0]         opc_r, opc_nxt;
  logic [2:0]         aop_r, aop_nxt;
  val_t               prod_r, prod_nxt;
  val_t               res_r, res_nxt;
  status_t            stat_r, stat_nxt;

  vchain_cmd_t        vcmd;
  val_t               vdata;
  ochain_cmd_t        ocmd;
  op_entry_t          odata;
  logic               div_start;
  logic               div_done;
  val_t               div_q;

  val_t               vq [VAL_DEPTH];
  op_entry_t          oq [OP_DEPTH];

  // top-of-stack views
  val_t               va, vb;
  op_entry_t          otop;
  logic               top_pops;
  status_t            efin;

  assign va   = vq[0];
  assign vb   = vq[1];
  assign otop = oq[0];
  // unary minus on top yields only to strictly lower incoming priority
  assign top_pops = (otop[2:0] == OP_NEG) ? (otop[5:3] > prio_r) : (otop[5:3] >= prio_r);

  // ---------------- cell chains ----------------
  genvar gi;
  generate
    for (gi = 0; gi < VAL_DEPTH; gi++) begin : g_val
      cell_cmd_t c;
      val_t      up, dn;
      always_comb begin
        case (vcmd)
          VC_PUSH: c = CELL_UP;
          VC_REPL: c = (gi == 0) ? CELL_UP : CELL_HOLD;
          VC_BIN:  c = (gi == 0) ? CELL_UP : CELL_DOWN;
          default: c = CELL_HOLD;
        endcase
      end
      if (gi == 0) begin : g_head
        assign up = vdata;
      end else begin : g_body
        assign up = vq[gi-1];
      end
      if (gi == VAL_DEPTH - 1) begin : g_tail
        assign dn = vq[gi];
      end else begin : g_mid
        assign dn = vq[gi+1];
      end
      iee_val_cell u_cell (.clk(clk), .cmd(c), .up_val(up), .down_val(dn), .q(vq[gi]));
    end

    for (gi = 0; gi < OP_DEPTH; gi++) begin : g_op
      cell_cmd_t c;
      op_entry_t up, dn;
      always_comb begin
        case (ocmd)
          OC_PUSH: c = CELL_UP;
          OC_POP:  c = CELL_DOWN;
          default: c = CELL_HOLD;
        endcase
      end
      if (gi == 0) begin : g_head
        assign up = odata;
      end else begin : g_body
        assign up = oq[gi-1];
      end
      if (gi == OP_DEPTH - 1) begin : g_tail
        assign dn = oq[gi];
      end else begin : g_mid
        assign dn = oq[gi+1];
      end
      iee_op_cell u_cell (.clk(clk), .cmd(c), .up_val(up), .down_val(dn), .q(oq[gi]));
    end
  endgenerate

  iee_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (vb),
    .den   (va),
    .done  (div_done),
    .quot  (div_q)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      ocnt_r  <= '0;
      vcnt_r  <= '0;
      perr_r  <= ST_OK;
      eerr_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      ocnt_r  <= ocnt_nxt;
      vcnt_r  <= vcnt_nxt;
      perr_r  <= perr_nxt;
      eerr_r  <= eerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    opc_r  <= opc_nxt;
    aop_r  <= aop_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    ocnt_nxt  = ocnt_r;
    vcnt_nxt  = vcnt_r;
    perr_nxt  = perr_r;
    eerr_nxt  = eerr_r;
    prio_nxt  = prio_r;
    opc_nxt   = opc_r;
    aop_nxt   = aop_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    vcmd      = VC_HOLD;
    vdata     = va;
    ocmd      = OC_HOLD;
    odata     = {2'b00, prio_r, opc_r};
    div_start = 1'b0;
    efin      = eerr_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_NUM: begin
              if (vcnt_r == VCNT_W'(VAL_DEPTH)) begin
                if (eerr_r == ST_OK) eerr_nxt = ST_OVERFLOW;
              end else begin
                vcmd     = VC_PUSH;
                vdata    = val_t'(in_number_value);
                vcnt_nxt = vcnt_r + 1'b1;
              end
            end
            MODE_OPER: begin
              if (in_operator_code > OP_NEG) begin
                if (perr_r == ST_OK) perr_nxt = ST_LEX_ERR;
              end else begin
                prio_nxt  = in_priority_req;
                opc_nxt   = in_operator_code;
                state_nxt = S_POP_OP;
              end
            end
            MODE_OPEN: begin
              if (ocnt_r == OCNT_W'(OP_DEPTH)) begin
                if (eerr_r == ST_OK) eerr_nxt = ST_OVERFLOW;
              end else begin
                ocmd     = OC_PUSH;
                odata    = BRACKET_ENTRY;
                ocnt_nxt = ocnt_r + 1'b1;
              end
            end
            MODE_CLOSE: state_nxt = S_POP_CLOSE;
            MODE_END:   state_nxt = S_POP_END;
            default: begin
              if (perr_r == ST_OK) perr_nxt = ST_LEX_ERR;
            end
          endcase
        end
      end

      S_POP_OP: begin
        if (ocnt_r != '0 && !otop[7] && top_pops) begin
          ocmd      = OC_POP;
          ocnt_nxt  = ocnt_r - 1'b1;
          aop_nxt   = otop[2:0];
          ret_nxt   = S_POP_OP;
          state_nxt = S_EXEC;
        end else begin
          if (ocnt_r == OCNT_W'(OP_DEPTH)) begin
            if (eerr_r == ST_OK) eerr_nxt = ST_OVERFLOW;
          end else begin
            ocmd     = OC_PUSH;
            ocnt_nxt = ocnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_POP_CLOSE: begin
        if (ocnt_r == '0) begin
          if (perr_r == ST_OK) perr_nxt = ST_UNMATCHED;
          state_nxt = S_IDLE;
        end else begin
          ocmd     = OC_POP;
          ocnt_nxt = ocnt_r - 1'b1;
          if (otop[7]) begin
            state_nxt = S_IDLE;
          end else begin
            aop_nxt   = otop[2:0];
            ret_nxt   = S_POP_CLOSE;
            state_nxt = S_EXEC;
          end
        end
      end

      S_POP_END: begin
        if (ocnt_r == '0) begin
          if (eerr_r == ST_OK) begin
            if (vcnt_r == '0)                 efin = ST_MISSING;
            else if (vcnt_r != VCNT_W'(1))    efin = ST_EXTRA;
          end
          stat_nxt  = (perr_r != ST_OK) ? perr_r : efin;
          res_nxt   = (stat_nxt == ST_OK) ? va : '0;
          state_nxt = S_OUT;
        end else begin
          ocmd     = OC_POP;
          ocnt_nxt = ocnt_r - 1'b1;
          if (otop[7]) begin
            if (perr_r == ST_OK) perr_nxt = ST_UNCLOSED;
          end else begin
            aop_nxt   = otop[2:0];
            ret_nxt   = S_POP_END;
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        state_nxt = ret_r;
        if (aop_r == OP_NEG) begin
          if (vcnt_r == '0) begin
            if (eerr_r == ST_OK) eerr_nxt = ST_MISSING;
          end else begin
            vcmd  = VC_REPL;
            vdata = -va;
          end
        end else if (vcnt_r < VCNT_W'(2)) begin
          if (eerr_r == ST_OK) eerr_nxt = ST_MISSING;
        end else begin
          case (aop_r)
            OP_ADD: begin
              vcmd     = VC_BIN;
              vdata    = vb + va;
              vcnt_nxt = vcnt_r - 1'b1;
            end
            OP_SUB: begin
              vcmd     = VC_BIN;
              vdata    = vb - va;
              vcnt_nxt = vcnt_r - 1'b1;
            end
            OP_MUL: begin
              prod_nxt  = vb * va;
              state_nxt = S_MUL;
            end
            default: begin
              if (va == '0) begin
                if (eerr_r == ST_OK) eerr_nxt = ST_DIV_ZERO;
                vcmd     = VC_BIN;
                vdata    = '0;
                vcnt_nxt = vcnt_r - 1'b1;
              end else begin
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
          endcase
        end
      end

      S_MUL: begin
        vcmd      = VC_BIN;
        vdata     = prod_r;
        vcnt_nxt  = vcnt_r - 1'b1;
        state_nxt = ret_r;
      end

      S_DIV: begin
        if (div_done) begin
          vcmd      = VC_BIN;
          vdata     = div_q;
          vcnt_nxt  = vcnt_r - 1'b1;
          state_nxt = ret_r;
        end
      end

      S_OUT: begin
        if (!out_stall) begin
          ocnt_nxt  = '0;
          vcnt_nxt  = '0;
          perr_nxt  = ST_OK;
          eerr_nxt  = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_result_value = res_r;
  assign out_status       = stat_r;

  // ---------------- assertions ----------------
  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= VCNT_W'(VAL_DEPTH)) else $error("value count past depth");

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OCNT_W'(OP_DEPTH)) else $error("operator count past depth");

  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_result_value == '0))
    else $error("value shown with an error status");

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (vcnt_r == '0 && ocnt_r == '0 && perr_r == ST_OK))
    else $error("state not cleared after result");

  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV)) else $error("divider finished outside wait");

endmodule
`default_nettype wire

[tb/expr_checker.sv]
// Checker for the expression evaluator: watches both channels, predicts the
// end-of-expression value and status, and counts mismatches. Needs iee_pkg.
module expr_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire  [2:0]        in_mode,
  input  wire  [2:0]        in_operator_code,
  input  wire  [2:0]        in_priority_req,
  input  wire  signed [31:0] in_number_value,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire  signed [31:0] out_result_value,
  input  wire  [2:0]        out_status,
  output int                fail_count,
  output int                pending
);
  import iee_pkg::*;

  op_entry_t   ops[OP_DEPTH];
  int          n_ops;
  val_t        vals[VAL_DEPTH];
  int          n_vals;
  logic [2:0]  parse_err;
  logic [2:0]  eval_err;
  logic [34:0] answers[$];

  assign pending = answers.size();

  function automatic void note_eval(logic [2:0] code);
    if (eval_err == ST_OK) eval_err = code;
  endfunction

  function automatic void note_parse(logic [2:0] code);
    if (parse_err == ST_OK) parse_err = code;
  endfunction

  function automatic val_t magnitude(val_t x);
    return x[VAL_W-1] ? -x : x;
  endfunction

  function automatic void apply_op(logic [2:0] op);
    val_t a, b, r, q;
    if (op == OP_NEG) begin
      if (n_vals < 1) note_eval(ST_MISSING);
      else vals[n_vals-1] = -vals[n_vals-1];
      return;
    end
    if (n_vals < 2) begin
      note_eval(ST_MISSING);
      return;
    end
    a = vals[n_vals-1];
    b = vals[n_vals-2];
    case (op)
      OP_ADD: r = b + a;
      OP_SUB: r = b - a;
      OP_MUL: r = b * a;
      default: begin
        if (a == 0) begin
          note_eval(ST_DIV_ZERO);
          r = '0;
        end else begin
          // truncating divide on magnitudes; the most negative value wraps
          q = magnitude(b) / magnitude(a);
          r = (a[VAL_W-1] ^ b[VAL_W-1]) ? -q : q;
        end
      end
    endcase
    n_vals--;
    vals[n_vals-1] = r;
  endfunction

  function automatic void push_op(op_entry_t e);
    if (n_ops >= OP_DEPTH) note_eval(ST_OVERFLOW);
    else begin
      ops[n_ops] = e;
      n_ops++;
    end
  endfunction

  function automatic void evaluate_lexeme(logic [2:0] mode, logic [2:0] op,
                                          logic [2:0] prio, logic [31:0] num);
    op_entry_t t;
    logic found;
    logic [2:0] st;
    logic [31:0] v;
    found = 0;
    case (mode)
      MODE_NUM: begin
        if (n_vals >= VAL_DEPTH) note_eval(ST_OVERFLOW);
        else begin
          vals[n_vals] = num;
          n_vals++;
        end
      end
      MODE_OPER: begin
        if (op > OP_NEG) note_parse(ST_LEX_ERR);
        else begin
          while (n_ops > 0) begin
            t = ops[n_ops-1];
            if (t[7]) break;
            if ((t[2:0] == OP_NEG) ? (t[5:3] > prio) : (t[5:3] >= prio)) begin
              n_ops--;
              apply_op(t[2:0]);
            end else break;
          end
          push_op({2'b00, prio, op});
        end
      end
      MODE_OPEN: push_op(BRACKET_ENTRY);
      MODE_CLOSE: begin
        while (n_ops > 0) begin
          n_ops--;
          t = ops[n_ops];
          if (t[7]) begin
            found = 1;
            break;
          end
          apply_op(t[2:0]);
        end
        if (!found) note_parse(ST_UNMATCHED);
      end
      MODE_END: begin
        while (n_ops > 0) begin
          n_ops--;
          t = ops[n_ops];
          if (t[7]) note_parse(ST_UNCLOSED);
          else apply_op(t[2:0]);
        end
        if (n_vals == 0) note_eval(ST_MISSING);
        else if (n_vals > 1) note_eval(ST_EXTRA);
        st = (parse_err != ST_OK) ? parse_err : eval_err;
        v = (st == ST_OK) ? vals[0] : '0;
        answers.insert(answers.size(), {st, v});
        n_ops = 0;
        n_vals = 0;
        parse_err = ST_OK;
        eval_err = ST_OK;
      end
      default: note_parse(ST_LEX_ERR);
    endcase
  endfunction

  always @(posedge clk) begin
    logic [34:0] want;
    if (!rst_n) begin
      n_ops = 0;
      n_vals = 0;
      parse_err = ST_OK;
      eval_err = ST_OK;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        evaluate_lexeme(in_mode, in_operator_code, in_priority_req, in_number_value);
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $time,
                   out_result_value, out_status);
          fail_count <= fail_count + 1;
        end else begin
          want = answers.pop_front();
          if (want[31:0] !== out_result_value || want[34:32] !== out_status) begin
            $display("%0t: expected value %0d status %0d, got value %0d status %0d",
                     $time, $signed(want[31:0]), want[34:32], out_result_value,
                     out_status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

[tb/testbench.sv]
// Top of the expression evaluator testbench: clock, reset, lexeme stimulus,
// output stalls and the verdict. Needs iee_pkg, expr_checker and the block.
module testbench;
  import iee_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  wire         in_stall;
  logic [2:0]  in_mode = 0;
  logic [2:0]  in_operator_code = 0;
  logic [2:0]  in_priority_req = 0;
  logic signed [31:0] in_number_value = 0;
  wire         out_valid;
  logic        out_stall = 0;
  wire signed [31:0] out_result_value;
  wire [2:0]   out_status;
  int          fail_count;
  int          pending;

  // idling profile: percentages for sender gaps and receiver stalls
  int          send_idle = 0;
  int          recv_stall = 0;
  int          hold_off = 0;   // long receiver hold-off, in cycles
  int          quiet = 0;      // cycles with nothing accepted
  int          ends_sent = 0;

  // a lexeme to send
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  op;
    logic [2:0]  prio;
    logic [31:0] num;
  } lexeme_t;

  lexeme_t plan[$];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  infix_expression_evaluator_core uut (.*);

  expr_checker chk (.*);

  // Receiver: random stalls, or a long counted hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // Watchdog: a long stretch with nothing accepted means the block is stuck.
  // Even a drain of 31 divides plus stalls stays far below this limit.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("FAIL infix_expression_evaluator_core");
      $finish;
    end
  end

  function automatic lexeme_t mk(logic [2:0] m, logic [2:0] o = 0, logic [2:0] p = 0,
                                 logic [31:0] n = 0);
    lexeme_t l;
    l.mode = m;
    l.op = o;
    l.prio = p;
    l.num = n;
    return l;
  endfunction

  // append one lexeme to the send queue
  function automatic void queue_lex(lexeme_t l);
    plan.insert(plan.size(), l);
  endfunction

  function automatic logic [2:0] rand3();
    return 3'($urandom);
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0: return $urandom_range(9);
      1: return -$urandom_range(9);
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // usual precedence: add/sub 1, mul/div 2, unary minus 3, sometimes random
  function automatic lexeme_t rand_oper(logic [2:0] o);
    logic [2:0] p;
    p = (o == OP_NEG) ? 3'd3 : (o >= OP_MUL) ? 3'd2 : 3'd1;
    if ($urandom_range(9) == 0) p = rand3();
    return mk(MODE_OPER, o, p, $urandom);
  endfunction

  // Well-formed expression of random shape, roughly depth-bounded.
  function automatic void gen_expr(int depth);
    int k;
    if ($urandom_range(2) == 0) queue_lex(rand_oper(OP_NEG));
    if (depth > 0 && $urandom_range(3) == 0) begin
      queue_lex(mk(MODE_OPEN, rand3(), rand3(), $urandom));
      gen_expr(depth - 1);
      queue_lex(mk(MODE_CLOSE, rand3(), rand3(), $urandom));
    end else begin
      queue_lex(mk(MODE_NUM, rand3(), rand3(), rand_num()));
    end
    k = (depth > 0) ? $urandom_range(2) : 0;
    repeat (k) begin
      queue_lex(rand_oper(3'($urandom_range(3))));
      gen_expr(depth - 1);
    end
  endfunction

  // Noise lexeme: anything the fields allow, bad modes and codes included.
  function automatic lexeme_t rand_any();
    return mk(rand3(), rand3(), rand3(), $urandom);
  endfunction

  task automatic send_plan();
    while (plan.size() > 0) begin
      if ($urandom_range(99) < send_idle) begin
        in_valid <= 0;
        @(posedge clk);
      end else begin
        {in_mode, in_operator_code, in_priority_req, in_number_value} <= plan.pop_front();
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_results();
    while (pending > 0) @(posedge clk);
  endtask

  initial begin
    int items;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: extremes, each operator and the error cases marked below.
    queue_lex(mk(MODE_NUM, 0, 0, 32'h7fff_ffff));
    queue_lex(mk(MODE_OPER, OP_ADD, 1, 0));
    queue_lex(mk(MODE_NUM, 7, 7, 32'h1));
    queue_lex(mk(MODE_END));                       // wrap
    queue_lex(mk(MODE_NUM, 0, 0, 32'h8000_0000));
    queue_lex(mk(MODE_OPER, OP_DIV, 2, 0));
    queue_lex(mk(MODE_NUM, 0, 0, 32'hffff_ffff));
    queue_lex(mk(MODE_END));                       // min / -1
    queue_lex(mk(MODE_OPER, OP_NEG, 3, 0));
    queue_lex(mk(MODE_NUM, 0, 0, -7));
    queue_lex(mk(MODE_OPER, OP_MUL, 2, 0));
    queue_lex(mk(MODE_NUM, 0, 0, 3));
    queue_lex(mk(MODE_OPER, OP_SUB, 1, 0));
    queue_lex(mk(MODE_NUM, 0, 0, 0));
    queue_lex(mk(MODE_OPER, OP_DIV, 2, 0));
    queue_lex(mk(MODE_NUM, 0, 0, 0));
    queue_lex(mk(MODE_END));                       // divide by zero
    queue_lex(mk(3'd6));
    queue_lex(mk(MODE_OPER, 3'd7, 0, 0));
    queue_lex(mk(MODE_END));                       // bad lexemes
    queue_lex(mk(MODE_CLOSE));
    queue_lex(mk(MODE_OPEN));
    queue_lex(mk(MODE_END));                       // unmatched close wins
    queue_lex(mk(MODE_NUM, 0, 0, 1));
    queue_lex(mk(MODE_NUM, 0, 0, 2));
    queue_lex(mk(MODE_END));                       // extra operands
    send_plan();
    wait_results();

    // Overflow of both stacks.
    repeat (34) queue_lex(mk(MODE_NUM, 0, 0, $urandom));
    queue_lex(mk(MODE_END));
    repeat (34) queue_lex(mk(MODE_OPEN));
    queue_lex(mk(MODE_END));
    repeat (34) queue_lex(mk(MODE_OPER, OP_NEG, 0, 0));
    queue_lex(mk(MODE_NUM, 0, 0, 5));
    queue_lex(mk(MODE_END));
    send_plan();
    wait_results();

    // Back pressure: receiver holds off while expressions keep coming.
    hold_off <= 400;
    repeat (6) begin
      gen_expr(2);
      queue_lex(mk(MODE_END));
    end
    send_plan();
    wait_results();

    // Random phases with the four idling profiles.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1) ? 70 : (ph == 3) ? 14 : 0;
      recv_stall = (ph == 2) ? 70 : (ph == 3) ? 14 : 0;
      items = 0;
      while (items < 415) begin
        if ($urandom_range(9) < 8) gen_expr(3);
        else repeat ($urandom_range(1, 6)) queue_lex(rand_any());
        if ($urandom_range(9) == 0) queue_lex(rand_any());
        queue_lex(mk(MODE_END));
        items += plan.size();
        send_plan();
      end
      wait_results();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS infix_expression_evaluator_core");
    end else begin
      $display("FAIL infix_expression_evaluator_core");
    end
    $finish;
  end

endmodule

[files.f]
src/iee_pkg.sv
src/iee_val_cell.sv
src/iee_op_cell.sv
src/iee_divider.sv
src/infix_expression_evaluator_core.sv
tb/expr_checker.sv
tb/testbench.sv
